// File: hdl/tevq_pkg.sv
// Shared constants, codes and a helper function of the timed event queue.
`default_nettype none
package tevq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IW = $clog2(QUEUE_DEPTH);

  localparam int ID_W = 32;
  localparam int TIME_W = 48;
  localparam int ST_W = 3;
  localparam int MODE_W = 2;
  localparam int SLOT_W = TIME_W + 2 * ID_W;

  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd3;

  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_RUNNING = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTHING_DUE = 3'd4;
  localparam logic [ST_W-1:0] ST_DISCARDED = 3'd5;
  localparam logic [ST_W-1:0] ST_SHUT_DOWN = 3'd6;

  // Returns {any_free, index} of the lowest entry whose used bit is clear.
  function automatic logic [IW:0] first_free(input logic [QUEUE_DEPTH-1:0] used);
    logic [IW:0] r;
    r = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!used[i]) begin
        r = {1'b1, IW'(i)};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/timed_event_queue_with_cancel_unit.sv
// Top level of the timed event queue with cancel.
`default_nettype none
// The block keeps up to QUEUE_DEPTH pending events, each an id with an absolute
// deadline, in a slot RAM, and the set of live ids in a second RAM; used bits
// for both sit in flip-flops and are cleared by reset and by shutdown. Every
// input transfer gives exactly one result transfer. Commands are handled one at
// a time: the input is ready only while the block is idle and the result has
// been taken. An add or a cancel runs one pass over the live-id RAM, a tick one
// pass over the slot RAM to find the head and then, if an entry is due, one pass
// over the live-id RAM. Each pass reads one entry per cycle; a shutdown, an add
// while shut down or a cancel of id 0 runs no pass and goes straight to the result.
// Ties between equal deadlines are served oldest insertion first.
module timed_event_queue_with_cancel_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: event_id_in [31:0], deadline [79:32], now_time [127:80]
  input  wire logic [tevq_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: mode [1:0]
  input  wire logic [tevq_pkg::MODE_W-1:0]     s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tdata: event_id_out [31:0], status [34:32], zero fill [39:35]
  output logic      [tevq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import tevq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LSCAN, S_LDONE, S_HSCAN, S_HDONE, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [ID_W-1:0] id_q, id_d, key_q, key_d;
  logic [TIME_W-1:0] dl_q, dl_d, now_q, now_d;
  logic found_q, found_d;
  logic [IW-1:0] fidx_q, fidx_d;
  logic best_vld_q, best_vld_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_dl_q, best_dl_d;
  logic [ID_W-1:0] best_id_q, best_id_d, best_ord_q, best_ord_d;
  logic [QUEUE_DEPTH-1:0] slot_used_q, slot_used_d, live_used_q, live_used_d;
  logic [ID_W-1:0] last_id_q, last_id_d, ins_cnt_q, ins_cnt_d;
  logic running_q, running_d;
  logic [IW-1:0] iss_q, iss_d, chk_idx_q, chk_idx_d;
  logic chk_vld_q, chk_vld_d;
  logic [ID_W-1:0] rid_q, rid_d;
  logic [ST_W-1:0] status_q, status_d;

  logic slot_we, live_we;
  logic [IW-1:0] slot_waddr, live_waddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;
  logic [ID_W-1:0] live_wdata, live_rdata;

  logic [TIME_W-1:0] rd_dl;
  logic [ID_W-1:0] rd_id, rd_ord, next_id, age_e, age_b;
  logic [IW:0] free_slot, free_live;
  logic scan_end, live_hit, better, full;

  tevq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (iss_q),
    .rdata_o (slot_rdata)
  );

  tevq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (live_we),
    .waddr_i (live_waddr),
    .wdata_i (live_wdata),
    .raddr_i (iss_q),
    .rdata_o (live_rdata)
  );

  assign rd_dl = slot_rdata[TIME_W-1:0];
  assign rd_id = slot_rdata[TIME_W+ID_W-1:TIME_W];
  assign rd_ord = slot_rdata[SLOT_W-1:TIME_W+ID_W];
  // Age relative to the insert counter decides ties; larger is older.
  assign age_e = ins_cnt_q - rd_ord;
  assign age_b = ins_cnt_q - best_ord_q;
  assign next_id = (last_id_q == '1) ? ID_W'(1) : last_id_q + ID_W'(1);
  assign free_slot = first_free(slot_used_q);
  assign free_live = first_free(live_used_q);
  assign scan_end = chk_vld_q && (chk_idx_q == IW'(QUEUE_DEPTH - 1));
  assign live_hit = chk_vld_q && live_used_q[chk_idx_q] && (live_rdata == key_q);
  assign better = !best_vld_q || (rd_dl < best_dl_q) ||
                  ((rd_dl == best_dl_q) && (age_e > age_b));
  // An allocated id always needs a new live entry for the full check.
  assign full = !free_slot[IW] ||
                (((id_q == '0) || !found_q) && !free_live[IW]);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o = {{(OUT_DATA_W - ID_W - ST_W){1'b0}}, status_q, rid_q};

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    id_d = id_q;
    key_d = key_q;
    dl_d = dl_q;
    now_d = now_q;
    found_d = found_q;
    fidx_d = fidx_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_dl_d = best_dl_q;
    best_id_d = best_id_q;
    best_ord_d = best_ord_q;
    slot_used_d = slot_used_q;
    live_used_d = live_used_q;
    last_id_d = last_id_q;
    ins_cnt_d = ins_cnt_q;
    running_d = running_q;
    iss_d = iss_q + IW'(1);
    chk_vld_d = 1'b1;
    chk_idx_d = iss_q;
    rid_d = rid_q;
    status_d = status_q;
    slot_we = 1'b0;
    slot_waddr = free_slot[IW-1:0];
    slot_wdata = {ins_cnt_q, key_q, dl_q};
    live_we = 1'b0;
    live_waddr = free_live[IW-1:0];
    live_wdata = key_q;

    case (state_q)
      S_IDLE: begin
        iss_d = '0;
        chk_vld_d = 1'b0;
        found_d = 1'b0;
        best_vld_d = 1'b0;
        if (s_axis_tvalid_i) begin
          mode_d = s_axis_tuser_i;
          id_d = s_axis_tdata_i[ID_W-1:0];
          dl_d = s_axis_tdata_i[ID_W+TIME_W-1:ID_W];
          now_d = s_axis_tdata_i[ID_W+2*TIME_W-1:ID_W+TIME_W];
          rid_d = '0;
          case (s_axis_tuser_i)
            MODE_ADD: begin
              key_d = (s_axis_tdata_i[ID_W-1:0] != '0) ? s_axis_tdata_i[ID_W-1:0]
                                                       : next_id;
              if (!running_q) begin
                status_d = ST_NOT_RUNNING;
                state_d = S_OUT;
              end else begin
                state_d = S_LSCAN;
              end
            end
            MODE_CANCEL: begin
              key_d = s_axis_tdata_i[ID_W-1:0];
              if (s_axis_tdata_i[ID_W-1:0] == '0) begin
                status_d = ST_NOT_FOUND;
                state_d = S_OUT;
              end else begin
                state_d = S_LSCAN;
              end
            end
            MODE_TICK: begin
              state_d = S_HSCAN;
            end
            default: begin
              running_d = 1'b0;
              slot_used_d = '0;
              live_used_d = '0;
              ins_cnt_d = '0;
              status_d = ST_SHUT_DOWN;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_LSCAN: begin
        if (live_hit) begin
          found_d = 1'b1;
          fidx_d = chk_idx_q;
        end
        if (scan_end) begin
          state_d = S_LDONE;
        end
      end
      S_LDONE: begin
        state_d = S_OUT;
        case (mode_q)
          MODE_ADD: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              if (id_q == '0) begin
                last_id_d = key_q;
              end
              if (!found_q) begin
                live_we = 1'b1;
                live_used_d[free_live[IW-1:0]] = 1'b1;
              end
              slot_we = 1'b1;
              slot_used_d[free_slot[IW-1:0]] = 1'b1;
              ins_cnt_d = ins_cnt_q + ID_W'(1);
              rid_d = key_q;
              status_d = ST_OK;
            end
          end
          MODE_CANCEL: begin
            if (found_q) begin
              live_used_d[fidx_q] = 1'b0;
              status_d = ST_OK;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: begin
            rid_d = key_q;
            if (found_q) begin
              live_used_d[fidx_q] = 1'b0;
              status_d = ST_OK;
            end else begin
              status_d = ST_DISCARDED;
            end
          end
        endcase
      end
      S_HSCAN: begin
        if (chk_vld_q && slot_used_q[chk_idx_q] && better) begin
          best_vld_d = 1'b1;
          best_idx_d = chk_idx_q;
          best_dl_d = rd_dl;
          best_id_d = rd_id;
          best_ord_d = rd_ord;
        end
        if (scan_end) begin
          state_d = S_HDONE;
        end
      end
      S_HDONE: begin
        iss_d = '0;
        chk_vld_d = 1'b0;
        if (!best_vld_q || (best_dl_q > now_q)) begin
          status_d = ST_NOTHING_DUE;
          state_d = S_OUT;
        end else begin
          slot_used_d[best_idx_q] = 1'b0;
          key_d = best_id_q;
          state_d = S_LSCAN;
        end
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_ADD;
      id_q <= '0;
      key_q <= '0;
      dl_q <= '0;
      now_q <= '0;
      found_q <= 1'b0;
      fidx_q <= '0;
      best_vld_q <= 1'b0;
      best_idx_q <= '0;
      best_dl_q <= '0;
      best_id_q <= '0;
      best_ord_q <= '0;
      slot_used_q <= '0;
      live_used_q <= '0;
      last_id_q <= '0;
      ins_cnt_q <= '0;
      running_q <= 1'b1;
      iss_q <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      rid_q <= '0;
      status_q <= ST_OK;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      id_q <= id_d;
      key_q <= key_d;
      dl_q <= dl_d;
      now_q <= now_d;
      found_q <= found_d;
      fidx_q <= fidx_d;
      best_vld_q <= best_vld_d;
      best_idx_q <= best_idx_d;
      best_dl_q <= best_dl_d;
      best_id_q <= best_id_d;
      best_ord_q <= best_ord_d;
      slot_used_q <= slot_used_d;
      live_used_q <= live_used_d;
      last_id_q <= last_id_d;
      ins_cnt_q <= ins_cnt_d;
      running_q <= running_d;
      iss_q <= iss_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      rid_q <= rid_d;
      status_q <= status_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tevq_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module tevq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: verif/timed_event_queue_with_cancel_unit_tb.sv
// Self-checking testbench of the timed event queue with cancel.
`default_nettype none
module timed_event_queue_with_cancel_unit_tb;
  import tevq_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ST_W-1:0] status;
  } event_result_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i;
  logic [MODE_W-1:0] s_axis_tuser_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  timed_event_queue_with_cancel_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  // Shadow copy of the queue state.
  logic [TIME_W-1:0] q_deadline [QUEUE_DEPTH];
  logic [ID_W-1:0] q_id [QUEUE_DEPTH];
  logic [ID_W-1:0] q_order [QUEUE_DEPTH];
  logic q_used [QUEUE_DEPTH];
  logic [ID_W-1:0] lv_id [QUEUE_DEPTH];
  logic lv_used [QUEUE_DEPTH];
  logic [ID_W-1:0] id_counter;
  logic [ID_W-1:0] seq_counter;
  logic is_running;

  event_result_t pending_results [$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  logic [TIME_W-1:0] clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int live_index(logic [ID_W-1:0] id);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (lv_used[i] && lv_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_used[i] = 1'b0;
      lv_used[i] = 1'b0;
    end
  endfunction

  // Computes the result of one command and updates the shadow state.
  function automatic event_result_t queue_response(logic [MODE_W-1:0] mode,
      logic [ID_W-1:0] id_in, logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
    event_result_t r;
    int slot, lv, h;
    logic need_live;
    logic [ID_W-1:0] id, age_i, age_b;
    r = '0;
    id = id_in;
    slot = -1;
    lv = -1;
    h = -1;
    case (mode)
      MODE_ADD: begin
        if (!is_running) begin
          r.status = ST_NOT_RUNNING;
        end else begin
          for (int i = QUEUE_DEPTH - 1; i >= 0; i--) if (!q_used[i]) slot = i;
          need_live = !(id != 0 && live_index(id) >= 0);
          if (need_live)
            for (int i = QUEUE_DEPTH - 1; i >= 0; i--) if (!lv_used[i]) lv = i;
          if (slot < 0 || (need_live && lv < 0)) begin
            r.status = ST_FULL;
          end else begin
            if (id == 0) begin
              id_counter = id_counter + 1;
              if (id_counter == 0) id_counter = 1;
              id = id_counter;
              if (live_index(id) >= 0) need_live = 1'b0;
            end
            if (need_live) begin
              lv_id[lv] = id;
              lv_used[lv] = 1'b1;
            end
            q_deadline[slot] = dl;
            q_id[slot] = id;
            q_order[slot] = seq_counter;
            q_used[slot] = 1'b1;
            seq_counter = seq_counter + 1;
            r.id = id;
            r.status = ST_OK;
          end
        end
      end
      MODE_CANCEL: begin
        lv = (id == 0) ? -1 : live_index(id);
        if (lv < 0) r.status = ST_NOT_FOUND;
        else begin
          lv_used[lv] = 1'b0;
          r.status = ST_OK;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!q_used[i]) continue;
          if (h < 0 || q_deadline[i] < q_deadline[h]) h = i;
          else if (q_deadline[i] == q_deadline[h]) begin
            age_i = seq_counter - q_order[i];
            age_b = seq_counter - q_order[h];
            if (age_i > age_b) h = i;
          end
        end
        if (h < 0 || q_deadline[h] > now) r.status = ST_NOTHING_DUE;
        else begin
          lv = live_index(q_id[h]);
          r.id = q_id[h];
          q_used[h] = 1'b0;
          if (lv >= 0) begin
            lv_used[lv] = 1'b0;
            r.status = ST_OK;
          end else r.status = ST_DISCARDED;
        end
      end
      default: begin
        is_running = 1'b0;
        clear_shadow();
        seq_counter = '0;
        r.status = ST_SHUT_DOWN;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sends one command and queues the predicted result once it is accepted.
  // Valid is dropped only when the sender idles, so the next command can follow
  // in the same time step without a second assignment to valid.
  task automatic send_command(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= mode;
    s_axis_tdata_i <= {now, dl, id};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(queue_response(mode, id, dl, now));
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk_i) begin
    event_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_o[31:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata_o[31:0] !== want.id)
            report_mismatch("event_id_out", m_axis_tdata_o[31:0], want.id);
          if (m_axis_tdata_o[34:32] !== want.status)
            report_mismatch("status", ID_W'(m_axis_tdata_o[34:32]), ID_W'(want.status));
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** timed_event_queue_with_cancel_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic test_directed();
    send_command(MODE_TICK, '0, '0, '0);                   // empty queue
    send_command(MODE_CANCEL, '0, '0, '0);                 // cancel of id 0
    send_command(MODE_ADD, '0, 48'd100, '0);               // allocated id 1
    send_command(MODE_ADD, 32'd7, 48'd100, '0);            // tie, later insertion
    send_command(MODE_ADD, 32'd7, 48'd50, '0);             // id already live
    send_command(MODE_ADD, 32'hFFFF_FFFF, '1, '0);         // top id, top deadline
    send_command(MODE_ADD, '0, '0, '0);                    // deadline zero
    send_command(MODE_CANCEL, 32'd1, '0, '0);
    send_command(MODE_CANCEL, 32'd1, '0, '0);              // no longer live
    send_command(MODE_TICK, '0, '0, 48'd49);               // deadline zero fires
    send_command(MODE_TICK, '0, '0, 48'd49);               // nothing due
    send_command(MODE_TICK, '0, '0, 48'd100);              // id 7 fires
    send_command(MODE_TICK, '0, '0, 48'd100);              // id 1 discarded
    send_command(MODE_TICK, '0, '0, 48'd100);              // stale id 7 slot
    send_command(MODE_TICK, '0, '0, '1);
    send_command(MODE_TICK, '0, '0, '1);
    // Fill the queue until it refuses.
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) send_command(MODE_ADD, '0, 48'(i), '0);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) send_command(MODE_TICK, '0, '0, '1);
  endtask

  task automatic test_random(int count, logic with_shutdown);
    logic [ID_W-1:0] id;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(20);
      if ($urandom_range(19) == 0) id = $urandom;
      else if ($urandom_range(2) == 0) id = '0;
      else id = $urandom_range(24);
      if (pick < 40)
        send_command(MODE_ADD, id, ($urandom_range(9) == 0) ? rand48()
                     : clock_ms + $urandom_range(60), rand48());
      else if (pick < 55) send_command(MODE_CANCEL, id, rand48(), rand48());
      else if (pick < 98 || !with_shutdown)
        send_command(MODE_TICK, $urandom, rand48(),
                     ($urandom_range(15) == 0) ? rand48() : clock_ms);
      else send_command(MODE_SHUTDOWN, $urandom, rand48(), rand48());
    end
  endtask

  task automatic test_after_shutdown();
    send_command(MODE_SHUTDOWN, '0, '0, '0);
    send_command(MODE_SHUTDOWN, '0, '0, '0);
    send_command(MODE_ADD, '0, 48'd5, '0);
    send_command(MODE_CANCEL, 32'd3, '0, '0);
    send_command(MODE_TICK, '0, '0, '1);
    test_random(40, 1'b0);
  endtask

  initial begin
    int drain;
    errors = 0;
    quiet_cycles = 0;
    clock_ms = '0;
    clear_shadow();
    id_counter = '0;
    seq_counter = '0;
    is_running = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = MODE_ADD;
    m_axis_tready_i = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 52;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250, 1'b0);
    send_idle_pct = 52;
    recv_idle_pct = 16;
    test_random(250, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200, 1'b0);
    test_after_shutdown();
    s_axis_tvalid_i <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < STALL_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (2 * QUEUE_DEPTH + 10) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("** timed_event_queue_with_cancel_unit: PASSED **");
    else
      $display("** timed_event_queue_with_cancel_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
